// ----- design/plm_pkg.sv -----
package plm_pkg;

  // Default sizing
  localparam int DEF_MAX_POINTS = 16;
  localparam int DEF_X_WIDTH    = 16;
  localparam int DEF_Y_WIDTH    = 24;

  // Breakpoint count in use after reset
  localparam int ACTIVE_RESET = 9;

  // Command carried in the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Result region codes
  localparam int REGION_W = 2;
  localparam logic [REGION_W-1:0] REGION_LOW    = 2'd0;
  localparam logic [REGION_W-1:0] REGION_HIGH   = 2'd1;
  localparam logic [REGION_W-1:0] REGION_EXACT  = 2'd2;
  localparam logic [REGION_W-1:0] REGION_INTERP = 2'd3;

  // Status from the multiply/divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

// ----- design/plm_muldiv.sv -----
// Shared multiply then restoring divide: q = (dv * dy) / dx.
// Requires dv < dx, so the quotient fits in Y_WIDTH bits and
// only Y_WIDTH divide steps are needed.
module plm_muldiv #(
  parameter int X_WIDTH = plm_pkg::DEF_X_WIDTH,
  parameter int Y_WIDTH = plm_pkg::DEF_Y_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [X_WIDTH-1:0]   dv,
  input  logic [Y_WIDTH-1:0]   dy,
  input  logic [X_WIDTH-1:0]   dx,
  output logic [Y_WIDTH-1:0]   quot,
  output plm_pkg::md_stat_t    stat
);
  import plm_pkg::*;

  localparam int ACC_W = X_WIDTH + Y_WIDTH;
  localparam int CNT_W = $clog2(Y_WIDTH + 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_DIV
  } md_state_t;

  md_state_t          state_r;
  logic [X_WIDTH-1:0] dv_r;
  logic [Y_WIDTH-1:0] dy_r;
  logic [X_WIDTH-1:0] dx_r;
  logic [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;

  // One restoring divide step on the remainder half of acc
  logic [X_WIDTH:0]   trial;
  logic [X_WIDTH:0]   diff;
  logic [X_WIDTH-1:0] rem_new;
  logic               qbit;

  always_comb begin
    trial   = {acc_r[ACC_W-1:Y_WIDTH], acc_r[Y_WIDTH-1]};
    diff    = trial - {1'b0, dx_r};
    qbit    = (trial >= {1'b0, dx_r});
    rem_new = qbit ? diff[X_WIDTH-1:0] : trial[X_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            dv_r    <= dv;
            dy_r    <= dy;
            dx_r    <= dx;
            state_r <= M_MUL;
          end
        end
        M_MUL: begin
          acc_r   <= ACC_W'(dv_r * dy_r);
          cnt_r   <= CNT_W'(Y_WIDTH);
          state_r <= M_DIV;
        end
        M_DIV: begin
          acc_r <= {rem_new, acc_r[Y_WIDTH-2:0], qbit};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign quot      = acc_r[Y_WIDTH-1:0];
  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = done_r;

endmodule

// ----- design/piecewise_linear_map_unit.sv -----
// Piecewise linear map with a breakpoint table of up to MAX_POINTS pairs.
// Input stream: tuser is the command (load or evaluate); tdata carries the
// slot index, breakpoint x and y, and the sample. A load writes one slot and
// gives no result. An evaluate gives one result on the output stream:
// mapped value and segment in tdata, region code in tuser.
// cfg_data sets the number of breakpoints in use; write it only when idle.
// An evaluate reads one table slot per cycle through the registered table
// read port: two reads for the end checks, one per step of the linear
// search, then the shared multiplier and restoring divider, a step to take
// the quotient and a step to load the output register. Clamped and exact
// cases skip the multiplier and divider. in_tready is low while an evaluate
// is in progress.
// The result sits in an output register. A stalled receiver holds it there;
// loads are still taken, but the next evaluate then waits for the register
// and in_tready stays low until the receiver takes the older result.
// Reset clears out_tvalid, returns the sequencer to idle and sets the active
// count to 9; table contents are undefined until loaded.
module piecewise_linear_map_unit #(
  parameter int MAX_POINTS = plm_pkg::DEF_MAX_POINTS,
  parameter int X_WIDTH    = plm_pkg::DEF_X_WIDTH,
  parameter int Y_WIDTH    = plm_pkg::DEF_Y_WIDTH,
  parameter int IDX_W      = $clog2(MAX_POINTS),
  parameter int AP_W       = $clog2(MAX_POINTS + 1),
  parameter int IN_W       = ((IDX_W + 2 * X_WIDTH + Y_WIDTH + 7) / 8) * 8,
  parameter int OUT_W      = ((Y_WIDTH + IDX_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: point_index, point_x, point_y, sample (low bits first)
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,
  // in_tuser: cmd
  input  logic                           in_tuser,
  // out_tdata: mapped_value, segment (low bits first)
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,
  // out_tuser: region
  output logic [plm_pkg::REGION_W-1:0]   out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [AP_W-1:0]                cfg_data
);
  import plm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_SRCH,
    S_MUL,
    S_DONE
  } state_t;

  // Input field positions
  localparam int PX_LO = IDX_W;
  localparam int PY_LO = PX_LO + X_WIDTH;
  localparam int SM_LO = PY_LO + Y_WIDTH;

  state_t             state_r;
  logic [AP_W-1:0]    active_points_r;
  logic [X_WIDTH-1:0] s_r;
  logic [IDX_W-1:0]   last_r;
  logic [IDX_W-1:0]   pos_r;
  logic [X_WIDTH-1:0] xlo_r;
  logic [Y_WIDTH-1:0] ylo_r;
  logic               neg_r;
  logic [Y_WIDTH-1:0] res_y_r;
  logic [IDX_W-1:0]   res_seg_r;
  logic [REGION_W-1:0] res_reg_r;
  logic               out_tvalid_r;
  logic [Y_WIDTH-1:0] out_y_r;
  logic [IDX_W-1:0]   out_seg_r;
  logic [REGION_W-1:0] out_reg_r;
  logic               out_load;

  // Breakpoint table, one write and one registered read per cycle
  logic [X_WIDTH-1:0] x_mem [MAX_POINTS];
  logic [Y_WIDTH-1:0] y_mem [MAX_POINTS];
  logic [X_WIDTH-1:0] rd_x_r;
  logic [Y_WIDTH-1:0] rd_y_r;
  logic [IDX_W-1:0]   rd_addr;

  // Input field views
  logic [IDX_W-1:0]   in_idx;
  logic [X_WIDTH-1:0] in_x;
  logic [Y_WIDTH-1:0] in_y;
  logic [X_WIDTH-1:0] in_s;
  logic               in_fire;
  logic               wr_en;

  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_x    = in_tdata[PX_LO +: X_WIDTH];
  assign in_y    = in_tdata[PY_LO +: Y_WIDTH];
  assign in_s    = in_tdata[SM_LO +: X_WIDTH];
  assign in_fire = in_tvalid && in_tready;
  assign wr_en   = in_fire && (in_tuser == CMD_LOAD) &&
                   ({1'b0, in_idx} < (IDX_W + 1)'(MAX_POINTS));

  // Clamped last active index
  logic [AP_W-1:0]  used_n;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    if (active_points_r < AP_W'(2)) begin
      used_n = AP_W'(2);
    end else if (active_points_r > AP_W'(MAX_POINTS)) begin
      used_n = AP_W'(MAX_POINTS);
    end else begin
      used_n = active_points_r;
    end
    last_idx = IDX_W'(used_n - AP_W'(1));
  end

  // Read address for the next cycle's compare
  always_comb begin
    rd_addr = '0;
    case (state_r)
      S_IDLE: rd_addr = '0;
      S_LO:   rd_addr = last_r;
      S_HI:   rd_addr = IDX_W'(1);
      S_SRCH: rd_addr = pos_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[in_idx] <= in_x;
      y_mem[in_idx] <= in_y;
    end
    rd_x_r <= x_mem[rd_addr];
    rd_y_r <= y_mem[rd_addr];
  end

  // Shared multiply/divide
  logic               md_start;
  logic [X_WIDTH-1:0] md_dv;
  logic [X_WIDTH-1:0] md_dx;
  logic [Y_WIDTH-1:0] md_dy;
  logic               y_down;
  logic [Y_WIDTH-1:0] md_quot;
  md_stat_t           md_stat;
  logic               srch_more;

  assign srch_more = (pos_r < last_r) && (s_r > rd_x_r);
  assign y_down    = (rd_y_r < ylo_r);
  assign md_dv     = s_r - xlo_r;
  assign md_dx     = rd_x_r - xlo_r;
  assign md_dy     = y_down ? (ylo_r - rd_y_r) : (rd_y_r - ylo_r);
  assign md_start  = (state_r == S_SRCH) && !srch_more && (s_r != rd_x_r);

  plm_muldiv #(
    .X_WIDTH (X_WIDTH),
    .Y_WIDTH (Y_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .dv    (md_dv),
    .dy    (md_dy),
    .dx    (md_dx),
    .quot  (md_quot),
    .stat  (md_stat)
  );

  // Finished result moves into a free or freeing output register
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_tvalid_r    <= 1'b0;
      active_points_r <= AP_W'(ACTIVE_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_points_r <= cfg_data;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_y_r      <= res_y_r;
        out_seg_r    <= res_seg_r;
        out_reg_r    <= res_reg_r;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_tuser == CMD_EVAL)) begin
            s_r     <= in_s;
            last_r  <= last_idx;
            state_r <= S_LO;
          end
        end
        S_LO: begin
          if (s_r <= rd_x_r) begin
            res_y_r   <= rd_y_r;
            res_seg_r <= '0;
            res_reg_r <= REGION_LOW;
            state_r   <= S_DONE;
          end else begin
            xlo_r   <= rd_x_r;
            ylo_r   <= rd_y_r;
            state_r <= S_HI;
          end
        end
        S_HI: begin
          if (s_r >= rd_x_r) begin
            res_y_r   <= rd_y_r;
            res_seg_r <= last_r;
            res_reg_r <= REGION_HIGH;
            state_r   <= S_DONE;
          end else begin
            pos_r   <= IDX_W'(1);
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (srch_more) begin
            xlo_r <= rd_x_r;
            ylo_r <= rd_y_r;
            pos_r <= pos_r + 1'b1;
          end else if (s_r == rd_x_r) begin
            res_y_r   <= rd_y_r;
            res_seg_r <= pos_r;
            res_reg_r <= REGION_EXACT;
            state_r   <= S_DONE;
          end else begin
            neg_r     <= y_down;
            res_seg_r <= pos_r;
            res_reg_r <= REGION_INTERP;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          if (md_stat.done) begin
            res_y_r <= neg_r ? (ylo_r - md_quot) : (ylo_r + md_quot);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_seg_r, out_y_r});
  assign out_tuser  = out_reg_r;

`ifndef SYNTH
  // Divider runs only while the sequencer waits on it
  a_md_owned: assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.busy |-> (state_r == S_MUL))
    else $error("divider busy outside multiply state");

  // A new result is only loaded from the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without finishing an evaluate");

  // Search pointer stays within the active table
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (pos_r <= last_r) && (pos_r != '0))
    else $error("search pointer out of range");

  // Exact and interpolated results never name slot zero
  a_seg_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && ((out_reg_r == REGION_EXACT) || (out_reg_r == REGION_INTERP))
      |-> (out_seg_r != '0))
    else $error("inner region with segment zero");
`endif

endmodule

// ----- dv/piecewise_linear_map_unit_tb.sv -----
module piecewise_linear_map_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plm_pkg::*;

  localparam int MAX_PTS   = DEF_MAX_POINTS;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 32;
  localparam int SETTLE    = 60;    // above the worst evaluate latency
  localparam int HOLD_CYC  = 300;   // long receiver hold-off
  localparam int WDOG_MAX  = 3000;  // cycles with no transaction at all
  localparam int ITEM_GOAL = 1650;

  // one mapped result as seen on the output stream
  typedef struct packed {
    logic [23:0]         value;
    logic [3:0]          seg;
    logic [REGION_W-1:0] region;
  } map_res_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic [REGION_W-1:0] out_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [4:0]          cfg_data;

  // shadow copy of the breakpoint table and the active count
  logic [15:0] bp_x [MAX_PTS];
  logic [23:0] bp_y [MAX_PTS];
  logic [4:0]  active_cnt;

  map_res_t    pending_maps [$];
  int unsigned fail_cnt = 0;
  int unsigned items_sent;
  int unsigned quiet_cycles = 0;
  bit          idle_on;
  bit          hold_req = 1'b0;

  piecewise_linear_map_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // active count as the block uses it
  function automatic int unsigned used_count();
    int unsigned n;
    n = active_cnt;
    if (n < 2) n = 2;
    if (n > MAX_PTS) n = MAX_PTS;
    return n;
  endfunction

  // map a sample through the shadow table
  function automatic map_res_t map_sample(input logic [15:0] s);
    int unsigned last, pos;
    logic [63:0] dv, dx, yl, yh, q;
    map_res_t    r;
    last     = used_count() - 1;
    r.value  = '0;
    r.seg    = '0;
    r.region = REGION_LOW;
    if (s <= bp_x[0]) begin
      r.value = bp_y[0];
    end else if (s >= bp_x[last]) begin
      r.value  = bp_y[last];
      r.seg    = 4'(last);
      r.region = REGION_HIGH;
    end else begin
      pos = 1;
      while (pos < last && s > bp_x[pos]) pos++;
      r.seg = 4'(pos);
      if (s == bp_x[pos]) begin
        r.value  = bp_y[pos];
        r.region = REGION_EXACT;
      end else begin
        r.region = REGION_INTERP;
        dv = 64'(s) - 64'(bp_x[pos-1]);
        dx = 64'(bp_x[pos]) - 64'(bp_x[pos-1]);
        yl = 64'(bp_y[pos-1]);
        yh = 64'(bp_y[pos]);
        if (dx == 0) begin
          r.value = yl[23:0];
        end else if (yh >= yl) begin
          q       = (dv * (yh - yl)) / dx;
          r.value = 24'(yl + q);
        end else begin
          q       = (dv * (yl - yh)) / dx;
          r.value = 24'(yl - q);
        end
      end
    end
    return r;
  endfunction

  // sample biased toward active breakpoints and the extremes of the input range
  function automatic logic [15:0] pick_sample();
    int unsigned n, r, k;
    n = used_count();
    r = $urandom_range(0, 99);
    k = $urandom_range(0, n - 1);
    if (r < 25) return bp_x[k];
    if (r < 30) return bp_x[k] + 16'd1;
    if (r < 35) return bp_x[k] - 16'd1;
    if (r < 40) return 16'h0000;
    if (r < 45) return 16'hFFFF;
    if (r < 85) return 16'($urandom_range(bp_x[0], bp_x[n-1]));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // drive one input transaction, update the shadow state on acceptance
  task automatic send_item(input logic cmd, input logic [IN_W-1:0] data);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (cmd == CMD_LOAD) begin
      bp_x[data[3:0]] = data[19:4];
      bp_y[data[3:0]] = data[43:20];
    end else begin
      pending_maps.push_back(map_sample(data[59:44]));
    end
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [15:0] x, input logic [23:0] y);
    send_item(CMD_LOAD, {4'd0, 16'd0, y, x, idx});
  endtask

  task automatic send_eval(input logic [15:0] s);
    send_item(CMD_EVAL, {4'd0, s, 24'd0, 16'd0, 4'd0});
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_active(input logic [4:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    active_cnt = v;
    cfg_valid <= 1'b0;
  endtask

  // strictly rising x across all slots, loaded in shuffled slot order
  task automatic load_ramp_table();
    logic [15:0] xs [MAX_PTS];
    logic [23:0] ys [MAX_PTS];
    logic [3:0]  order [MAX_PTS];
    logic [3:0]  t;
    int unsigned step_max, base, k, j, r;
    step_max = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4369);
    base     = $urandom_range(0, 65535 - 15 * step_max);
    if ($urandom_range(0, 4) == 0) base = 0;
    for (k = 0; k < MAX_PTS; k++) begin
      xs[k] = 16'(base);
      base  = base + $urandom_range(1, step_max);
      r     = $urandom_range(0, 9);
      if (r == 0) ys[k] = 24'h000000;
      else if (r == 1) ys[k] = 24'hFFFFFF;
      else if (r == 2 && k > 0) ys[k] = ys[k-1];
      else ys[k] = 24'($urandom_range(0, 24'hFFFFFF));
      order[k] = 4'(k);
    end
    if ($urandom_range(0, 4) == 0) xs[MAX_PTS-1] = 16'hFFFF;
    for (k = MAX_PTS - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (k = 0; k < MAX_PTS; k++) send_load(order[k], xs[order[k]], ys[order[k]]);
  endtask

  // table loaded, evaluates with the active count left at its reset value
  task automatic test_default_active();
    logic [23:0] ys [MAX_PTS] = '{24'h000000, 24'hFFFFFF, 24'h000100, 24'h800000,
                                  24'h7FFFFF, 24'h7FFFFF, 24'h000001, 24'hABCDEF,
                                  24'h123456, 24'h654321, 24'h0000FF, 24'hFF0000,
                                  24'h00FF00, 24'h5A5A5A, 24'hA5A5A5, 24'hFFFFFF};
    int unsigned k;
    idle_on = 1'b1;
    for (k = 0; k < MAX_PTS; k++) send_load(4'(k), 16'(1000 + k * 4000), ys[k]);
    // below, on and just above the first x; clamp high at slot eight
    send_eval(16'd0);
    send_eval(16'd999);
    send_eval(16'd1000);
    send_eval(16'd1001);
    send_eval(16'd3000);
    send_eval(16'd5000);
    send_eval(16'd7000);
    send_eval(16'd21000);
    send_eval(16'd22000);
    send_eval(16'd33000);
    send_eval(16'd40000);
    send_eval(16'hFFFF);
  endtask

  // full table, x and y extremes in the end slots
  task automatic test_directed_cases();
    write_active(5'd16);
    send_load(4'd0, 16'h0000, 24'hFFFFFF);
    send_load(4'd15, 16'hFFFF, 24'h000000);
    send_eval(16'd0);
    send_eval(16'd1);
    send_eval(16'd62000);
    send_eval(16'hFFFE);
    send_eval(16'hFFFF);
  endtask

  // active count at and beyond both ends of its range
  task automatic test_active_sweep();
    logic [4:0]  vals [7] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd9};
    int unsigned k, j;
    for (k = 0; k < 7; k++) begin
      write_active(vals[k]);
      load_ramp_table();
      for (j = 0; j < 12; j++) send_eval(pick_sample());
    end
  endtask

  // phases of table loads, noise loads and evaluates
  task automatic test_random_traffic();
    int unsigned r, n_ev, k;
    while (items_sent < ITEM_GOAL - 40) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) < 7) write_active(5'($urandom_range(2, 16)));
        else write_active(5'($urandom_range(0, 31)));
      end
      r = $urandom_range(0, 9);
      if (r < 6) begin
        load_ramp_table();
      end else if (r < 8) begin
        // overwrite a few slots, order may break
        repeat ($urandom_range(1, 3))
          send_load(4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)));
      end
      n_ev = $urandom_range(5, 40);
      for (k = 0; k < n_ev; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_load(4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)));
        else
          send_eval(pick_sample());
      end
    end
  endtask

  // receiver holds off while evaluates keep coming back to back
  task automatic test_output_backpressure();
    int unsigned k;
    drain_results();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_eval(pick_sample());
  endtask

  // receiver ready pattern
  initial begin : rx_ready_gen
    int unsigned len;
    bit          hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
      end else if (!idle_on) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        len = gap_len();
        if (len != 0) begin
          out_tready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  // compare each result transaction with the oldest expected map
  always @(posedge clk) begin : map_checker
    map_res_t exp_map;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_maps.size() == 0) begin
        $error("result with none expected: tdata %h tuser %h", out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        exp_map = pending_maps.pop_front();
        if (out_tdata[23:0] !== exp_map.value) begin
          $error("mapped_value expected %h actual %h", exp_map.value, out_tdata[23:0]);
          fail_cnt++;
        end
        if (out_tdata[27:24] !== exp_map.seg) begin
          $error("segment expected %0d actual %0d", exp_map.seg, out_tdata[27:24]);
          fail_cnt++;
        end
        if (out_tuser !== exp_map.region) begin
          $error("region expected %0d actual %0d", exp_map.region, out_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("piecewise_linear_map_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_LOAD;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    active_cnt   = 5'(ACTIVE_RESET);
    items_sent   = 0;
    idle_on      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_active();
    test_directed_cases();
    test_active_sweep();
    test_random_traffic();
    test_output_backpressure();
    drain_results();
    if (fail_cnt == 0 && pending_maps.size() == 0) begin
      $display("piecewise_linear_map_unit_tb OK");
    end else begin
      $display("piecewise_linear_map_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
